[hw/rtl/mbd_pkg.sv]
// Shared constants and types for the multi-button debouncer.
// No dependencies; imported by every other RTL file of the block.
package mbd_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int TIME_BITS   = 32;
	localparam int LIM_W       = 16;
	localparam int IDX_W       = 2;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [LIM_W-1:0] DEBOUNCE_RST = 16'd15;
	localparam logic [LIM_W-1:0] LONG_RST     = 16'd3000;

	// register select, taken from paddr[2]
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG     = 1'b1;

	// what one lane found for the current sample
	typedef struct packed {
		logic press;      // new level adopted and it is low
		logic cand;       // released with long mark set
		logic stable_nx;  // debounced level after this sample
		logic long_pre;   // long mark before any armed clear
	} lane_t;

	typedef struct packed {
		logic                   press_seen;
		logic [IDX_W-1:0]       press_index;
		logic                   long_press_any;
		logic [NUM_BUTTONS-1:0] stable_levels;
	} res_t;

endpackage

[hw/rtl/multi_button_debounce_long_press_top.sv]
// Top level: config registers, button lanes, merge stage and two-entry result buffer.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
//  channel | handshake          | beat payload
//  --------+--------------------+---------------------------------------------------
//  in      | in_valid/in_ready  | now_ms, levels, clear_press, arm_long_reset
//  out     | out_valid/out_ready| press_seen, press_index, long_press_any, stable_levels
//  cfg     | APB psel/penable   | debounce_ms @0x0, long_press_ms @0x4
//
// One beat per clock while in_ready is high; its result is registered in the buffer.
// Lanes and merge are combinational: one 32-bit subtract and two compares per lane.
// Reset sets stable levels high, clears other state and loads the limits with 15 and 3000.
// A result buffer of two entries lets input continue for one beat while out_ready is low.
module multi_button_debounce_long_press_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mbd_pkg::TIME_BITS-1:0]      now_ms,
	input  logic [mbd_pkg::NUM_BUTTONS-1:0]    levels,
	input  logic                               clear_press,
	input  logic                               arm_long_reset,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               press_seen,
	output logic [mbd_pkg::IDX_W-1:0]          press_index,
	output logic                               long_press_any,
	output logic [mbd_pkg::NUM_BUTTONS-1:0]    stable_levels,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mbd_pkg::ADDR_W-1:0]         paddr,
	input  logic [mbd_pkg::DATA_W-1:0]         pwdata,
	output logic [mbd_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import mbd_pkg::*;

	logic [LIM_W-1:0] debounce_q;
	logic [LIM_W-1:0] long_q;
	logic             cfg_wr;

	logic                   step;
	lane_t [NUM_BUTTONS-1:0] lanes;
	logic [NUM_BUTTONS-1:0] grant;
	res_t                   res;

	res_t main_q;
	res_t skid_q;
	logic out_valid_q;
	logic skid_valid_q;
	logic pop;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_q     <= LONG_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEBOUNCE: debounce_q <= pwdata[LIM_W-1:0];
				REG_LONG:     long_q     <= pwdata[LIM_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DEBOUNCE: prdata = DATA_W'(debounce_q);
			REG_LONG:     prdata = DATA_W'(long_q);
			default:      prdata = '0;
		endcase
	end

	// lanes and merge
	assign in_ready = !skid_valid_q;
	assign step     = in_valid && in_ready;

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		mbd_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.step         (step),
			.now_ms       (now_ms),
			.raw          (levels[g]),
			.debounce_ms  (debounce_q),
			.long_press_ms(long_q),
			.clear_grant  (grant[g]),
			.info         (lanes[g])
		);
	end

	mbd_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.clear_press   (clear_press),
		.arm_long_reset(arm_long_reset),
		.lanes         (lanes),
		.grant         (grant),
		.res           (res)
	);

	// result buffer: main register plus skid entry
	assign pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (step) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (step) begin
			if (!out_valid_q || pop)
				main_q <= res;
			else
				skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign press_seen     = main_q.press_seen;
	assign press_index    = main_q.press_index;
	assign long_press_any = main_q.long_press_any;
	assign stable_levels  = main_q.stable_levels;

`ifndef SYNTH
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without a main entry");

	a_stalled_beat_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(step && out_valid_q && !out_ready) |=> skid_valid_q)
		else $error("beat accepted under stall was not buffered");

	a_single_grant: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant))
		else $error("more than one long mark cleared by one armed reset");
`endif

endmodule

[hw/rtl/mbd_lane.sv]
// One button lane: raw-level history, change stamp, debounce and long-press timers.
// Depends on mbd_pkg.
module mbd_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [mbd_pkg::TIME_BITS-1:0] now_ms,
	input  logic                           raw,
	input  logic [mbd_pkg::LIM_W-1:0]     debounce_ms,
	input  logic [mbd_pkg::LIM_W-1:0]     long_press_ms,
	input  logic                           clear_grant,
	output mbd_pkg::lane_t                 info
);
	import mbd_pkg::*;

	logic                 stable_q;
	logic                 prev_q;
	logic                 long_q;
	logic [TIME_BITS-1:0] stamp_q;

	logic [TIME_BITS-1:0] stamp_eff;
	logic [TIME_BITS-1:0] elapsed;
	logic                 adopt;
	logic                 long_set;

	assign stamp_eff = (raw != prev_q) ? now_ms : stamp_q;
	assign elapsed   = now_ms - stamp_eff;
	assign adopt     = (elapsed > TIME_BITS'(debounce_ms)) && (stable_q != raw);
	assign long_set  = (elapsed > TIME_BITS'(long_press_ms)) && !raw;

	assign info.press     = adopt && !raw;
	assign info.cand      = raw && long_q;
	assign info.stable_nx = adopt ? raw : stable_q;
	assign info.long_pre  = long_q | long_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			prev_q   <= 1'b0;
			long_q   <= 1'b0;
			stamp_q  <= '0;
		end else if (step) begin
			stable_q <= info.stable_nx;
			prev_q   <= raw;
			long_q   <= info.long_pre & ~clear_grant;
			stamp_q  <= stamp_eff;
		end
	end

endmodule

[hw/rtl/mbd_merge.sv]
// Merge stage: press latch and index, armed long-reset grant, result fields.
// Depends on mbd_pkg; fed by the mbd_lane instances.
module mbd_merge (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step,
	input  logic                                   clear_press,
	input  logic                                   arm_long_reset,
	input  mbd_pkg::lane_t [mbd_pkg::NUM_BUTTONS-1:0] lanes,
	output logic [mbd_pkg::NUM_BUTTONS-1:0]        grant,
	output mbd_pkg::res_t                          res
);
	import mbd_pkg::*;

	logic             latch_q;
	logic [IDX_W-1:0] idx_q;
	logic             armed_q;

	logic             armed_eff;
	logic             latch_nx;
	logic [IDX_W-1:0] idx_nx;
	logic             armed_nx;
	logic             any_press;
	logic             found;
	logic             any_long;
	logic [NUM_BUTTONS-1:0] stable_nx;

	assign armed_eff = armed_q | arm_long_reset;

	always_comb begin
		grant     = '0;
		found     = 1'b0;
		any_press = 1'b0;
		idx_nx    = idx_q;
		any_long  = 1'b0;
		stable_nx = '0;
		for (int n = 0; n < NUM_BUTTONS; n++) begin
			if (armed_eff && lanes[n].cand && !found) begin
				grant[n] = 1'b1;
				found    = 1'b1;
			end
			if (lanes[n].press) begin
				any_press = 1'b1;
				idx_nx    = IDX_W'(n);
			end
			stable_nx[n] = lanes[n].stable_nx;
		end
		for (int n = 0; n < NUM_BUTTONS; n++) begin
			if (lanes[n].long_pre && !grant[n])
				any_long = 1'b1;
		end
	end

	assign latch_nx = (latch_q & ~clear_press) | any_press;
	assign armed_nx = armed_eff & ~found;

	assign res.press_seen     = latch_nx;
	assign res.press_index    = idx_nx;
	assign res.long_press_any = any_long & ~armed_nx;
	assign res.stable_levels  = stable_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
			idx_q   <= '0;
			armed_q <= 1'b0;
		end else if (step) begin
			latch_q <= latch_nx;
			idx_q   <= idx_nx;
			armed_q <= armed_nx;
		end
	end

endmodule
